// ----- sv/nearest_centroid_classifier_core_assert.svh -----
// Assertion macros shared by the nearest-centroid classifier modules.
`ifndef NEAREST_CENTROID_CLASSIFIER_CORE_ASSERT_SVH
`define NEAREST_CENTROID_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ncc assertion failed");

// Next-cycle implication, disabled during reset.
`define NCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ncc assertion failed");

`endif

// ----- sv/ncc_pkg.sv -----
// Shared constants and control structs for the nearest-centroid classifier.
`timescale 1ns / 1ps

package ncc_pkg;

   localparam int ACC_BITS  = 48;
   localparam int NORM_BITS = 38;

   // request kinds
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_FEATURE = 1'b1;

   // result status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // control bits of an item moving down the cell chain
   typedef struct packed {
      logic valid;
      logic feature;
      logic last;
      logic loaded;
      logic in_range;
   } item_ctrl_type;

   // control bits of the running minimum moving down the chain
   typedef struct packed {
      logic valid;
      logic loaded;
   } best_ctrl_type;

endpackage

// ----- sv/ncc_cell.sv -----
// One cluster cell: centroid memory, norm, dot accumulator and a min-chain step.
`timescale 1ns / 1ps

`include "nearest_centroid_classifier_core_assert.svh"

module ncc_cell #(
   parameter int CELL_INDEX   = 0,
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_FEATURES = 64,
   parameter int VALUE_BITS   = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  logic                                       clr_active,
   input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] clr_addr,
   input  logic [$clog2(MAX_CLUSTERS + 1)-1:0]        count_eff,
   input  ncc_pkg::item_ctrl_type                     item_ctrl_i,
   input  logic [$clog2(MAX_CLUSTERS)-1:0]            item_ci_i,
   input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] item_fi_i,
   input  logic signed [VALUE_BITS-1:0]               item_value_i,
   output ncc_pkg::item_ctrl_type                     item_ctrl_o,
   output logic [$clog2(MAX_CLUSTERS)-1:0]            item_ci_o,
   output logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] item_fi_o,
   output logic signed [VALUE_BITS-1:0]               item_value_o,
   input  ncc_pkg::best_ctrl_type                     best_ctrl_i,
   input  logic [$clog2(MAX_CLUSTERS)-1:0]            best_cluster_i,
   input  logic signed [ncc_pkg::ACC_BITS-1:0]        best_score_i,
   output ncc_pkg::best_ctrl_type                     best_ctrl_o,
   output logic [$clog2(MAX_CLUSTERS)-1:0]            best_cluster_o,
   output logic signed [ncc_pkg::ACC_BITS-1:0]        best_score_o
);

   localparam int CI_BITS   = $clog2(MAX_CLUSTERS);
   localparam int FI_BITS   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_CLUSTERS + 1);
   localparam int ACC_BITS  = ncc_pkg::ACC_BITS;
   localparam int NORM_BITS = ncc_pkg::NORM_BITS;
   localparam int PROD_BITS = 2 * VALUE_BITS;
   localparam int AW = ((ACC_BITS > PROD_BITS + 1) ? ACC_BITS : PROD_BITS + 1) + 1;
   localparam int NW = ((NORM_BITS > PROD_BITS) ? NORM_BITS : PROD_BITS) + 2;
   localparam int SW = ACC_BITS + 2;

   localparam logic signed [AW-1:0] ACC_MAX_W  = (AW'(1) <<< (ACC_BITS - 1)) - AW'(1);
   localparam logic signed [AW-1:0] ACC_MIN_W  = -ACC_MAX_W - AW'(1);
   localparam logic signed [NW-1:0] NORM_MAX_W = (NW'(1) <<< NORM_BITS) - NW'(1);
   localparam logic signed [SW-1:0] SC_MAX_W   = (SW'(1) <<< (ACC_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] SC_MIN_W   = -SC_MAX_W - SW'(1);

   typedef struct packed {
      logic feat;
      logic inr;
      logic load;
      logic last;
      logic loaded;
   } stage_ctrl_type;

   // stage A: item held in this cell, also handed on to the next one
   ncc_pkg::item_ctrl_type          a_ctrl_ff;
   logic [CI_BITS-1:0]              a_ci_ff;
   logic [FI_BITS-1:0]              a_fi_ff;
   logic signed [VALUE_BITS-1:0]    a_value_ff;
   logic                            load_hit;

   // centroid elements of this cluster
   logic signed [VALUE_BITS-1:0]    mem [MAX_FEATURES];
   logic signed [VALUE_BITS-1:0]    rd_ff;

   stage_ctrl_type                  b_ctrl_in;
   stage_ctrl_type                  b_ctrl_ff;
   logic signed [VALUE_BITS-1:0]    b_value_ff;

   logic signed [VALUE_BITS-1:0]    mult_b;
   logic signed [PROD_BITS-1:0]     m1_in;
   logic signed [PROD_BITS-1:0]     m1_ff;
   logic signed [PROD_BITS-1:0]     m2_ff;
   stage_ctrl_type                  c_ctrl_ff;

   logic signed [ACC_BITS-1:0]      acc_ff;
   logic signed [ACC_BITS-1:0]      acc_in;
   logic signed [AW-1:0]            acc_base;
   logic signed [AW-1:0]            acc_sum;
   logic                            clr_pend_ff;
   logic [NORM_BITS-1:0]            norm_ff;
   logic [NORM_BITS-1:0]            norm_in;
   logic signed [NW-1:0]            norm_x;
   logic signed [NW-1:0]            sq_sum;
   logic signed [NW-1:0]            t_full;
   logic signed [NW-1:0]            t_cap;
   logic signed [NW-1:0]            t_sel;
   logic                            d_last_ff;
   logic                            d_loaded_ff;

   logic signed [SW-1:0]            score_sum;
   logic signed [ACC_BITS-1:0]      score;
   logic                            take_own;
   ncc_pkg::best_ctrl_type          best_ctrl_ff;
   logic [CI_BITS-1:0]              best_cluster_ff;
   logic signed [ACC_BITS-1:0]      best_score_ff;

   // ---- stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else if (en) begin
         a_ctrl_ff  <= item_ctrl_i;
         a_ci_ff    <= item_ci_i;
         a_fi_ff    <= item_fi_i;
         a_value_ff <= item_value_i;
      end
   end

   assign load_hit = a_ctrl_ff.valid && !a_ctrl_ff.feature && a_ctrl_ff.in_range &&
                     (a_ci_ff == CI_BITS'(CELL_INDEX));

   assign item_ctrl_o  = a_ctrl_ff;
   assign item_ci_o    = a_ci_ff;
   assign item_fi_o    = a_fi_ff;
   assign item_value_o = a_value_ff;

   // read-first: a load sees the element it replaces
   always_ff @(posedge clock) begin
      if (clr_active) begin
         mem[clr_addr] <= '0;
      end else if (en && load_hit) begin
         mem[a_fi_ff] <= a_value_ff;
      end
      if (en) begin
         rd_ff <= mem[a_fi_ff];
      end
   end

   // ---- stage B
   always_comb begin
      b_ctrl_in.feat   = a_ctrl_ff.valid && a_ctrl_ff.feature;
      b_ctrl_in.inr    = a_ctrl_ff.in_range;
      b_ctrl_in.load   = load_hit;
      b_ctrl_in.last   = a_ctrl_ff.valid && a_ctrl_ff.feature && a_ctrl_ff.last;
      b_ctrl_in.loaded = a_ctrl_ff.loaded;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff <= '0;
      end else if (en) begin
         b_ctrl_ff  <= b_ctrl_in;
         b_value_ff <= a_value_ff;
      end
   end

   // ---- stage C: feature*element or new^2, and old^2
   assign mult_b = b_ctrl_ff.load ? b_value_ff : rd_ff;
   assign m1_in  = (b_ctrl_ff.feat && !b_ctrl_ff.inr) ? '0 :
                   PROD_BITS'(b_value_ff) * PROD_BITS'(mult_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctrl_ff <= '0;
      end else if (en) begin
         c_ctrl_ff <= b_ctrl_ff;
         m1_ff     <= m1_in;
         m2_ff     <= PROD_BITS'(rd_ff) * PROD_BITS'(rd_ff);
      end
   end

   // ---- stage D: accumulate -2p with saturation, update norm
   always_comb begin
      acc_base = clr_pend_ff ? '0 : AW'(acc_ff);
      acc_sum  = acc_base - (AW'(m1_ff) <<< 1);
      if (acc_sum > ACC_MAX_W) begin
         acc_in = ACC_MAX_W[ACC_BITS-1:0];
      end else if (acc_sum < ACC_MIN_W) begin
         acc_in = ACC_MIN_W[ACC_BITS-1:0];
      end else begin
         acc_in = acc_sum[ACC_BITS-1:0];
      end

      // clamp after adding new^2, then after removing old^2
      norm_x = $signed({{(NW - NORM_BITS){1'b0}}, norm_ff});
      sq_sum = norm_x + NW'(m1_ff);
      t_full = norm_x + NW'(m1_ff) - NW'(m2_ff);
      t_cap  = NORM_MAX_W - NW'(m2_ff);
      t_sel  = (sq_sum > NORM_MAX_W) ? t_cap : t_full;
      norm_in = t_sel[NW-1] ? '0 : t_sel[NORM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         clr_pend_ff <= 1'b0;
         norm_ff     <= '0;
         d_last_ff   <= 1'b0;
         d_loaded_ff <= 1'b0;
      end else if (en) begin
         if (c_ctrl_ff.feat) begin
            acc_ff      <= acc_in;
            clr_pend_ff <= c_ctrl_ff.last;
         end
         if (c_ctrl_ff.load) begin
            norm_ff <= norm_in;
         end
         d_last_ff   <= c_ctrl_ff.last;
         d_loaded_ff <= c_ctrl_ff.loaded;
      end
   end

   // ---- stage E: score and one step of the running minimum
   always_comb begin
      score_sum = SW'(acc_ff) + $signed({{(SW - NORM_BITS){1'b0}}, norm_ff});
      if (score_sum > SC_MAX_W) begin
         score = SC_MAX_W[ACC_BITS-1:0];
      end else if (score_sum < SC_MIN_W) begin
         score = SC_MIN_W[ACC_BITS-1:0];
      end else begin
         score = score_sum[ACC_BITS-1:0];
      end
      // strict compare keeps the lower index on ties
      take_own = (CELL_INDEX == 0) ||
                 ((CNT_BITS'(CELL_INDEX) < count_eff) && (score < best_score_i));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ctrl_ff <= '0;
      end else if (en) begin
         best_ctrl_ff.valid  <= d_last_ff;
         best_ctrl_ff.loaded <= d_loaded_ff;
         best_cluster_ff     <= take_own ? CI_BITS'(CELL_INDEX) : best_cluster_i;
         best_score_ff       <= take_own ? score : best_score_i;
      end
   end

   assign best_ctrl_o    = best_ctrl_ff;
   assign best_cluster_o = best_cluster_ff;
   assign best_score_o   = best_score_ff;

   `NCC_ASSERT_IMPL(a_best_align, clock, reset, CELL_INDEX != 0, best_ctrl_i.valid == d_last_ff)
   `NCC_ASSERT_IMPL(a_clear_empty, clock, reset, clr_active, !a_ctrl_ff.valid)
   `NCC_ASSERT_IMPL(a_last_sets_pend, clock, reset, d_last_ff, clr_pend_ff)

endmodule

// ----- sv/nearest_centroid_classifier_core.sv -----
// Top level of the nearest-centroid classifier: input, cell chain, result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_type, req_centroid_index,
//                                              req_feature_index, req_value, req_last
//   rsp      out        rsp_valid/rsp_ready    rsp_cluster, rsp_best_score, rsp_status
//   csr      in         csr_valid/csr_ready    csr_data (cluster_count)
//
// One item per cycle while req_ready is high. An item walks the chain one cell per cycle
//   unless stalled; each cell runs a five-step pipe (input register, memory read,
//   multiply, accumulate, score/compare). The result of a last feature passes down to the
//   last cell, through the rest of its pipe there, and into the result register or its spare.
// After reset every centroid memory is cleared, one address per cycle in all cells
//   at once: req_ready stays low until the last address is cleared. csr writes always go in.
// The chain stalls only when a result reaches its end while the result register and
//   the spare register behind it are both full; rsp_ready never reaches req_ready.
`timescale 1ns / 1ps

`include "nearest_centroid_classifier_core_assert.svh"

module nearest_centroid_classifier_core #(
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_FEATURES = 64,
   parameter int VALUE_BITS   = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic                                          req_type,
   input  logic [$clog2(MAX_CLUSTERS)-1:0]               req_centroid_index,
   input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] req_feature_index,
   input  logic signed [VALUE_BITS-1:0]                  req_value,
   input  logic                                          req_last,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic [$clog2(MAX_CLUSTERS)-1:0]               rsp_cluster,
   output logic signed [ncc_pkg::ACC_BITS-1:0]           rsp_best_score,
   output logic                                          rsp_status,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [$clog2(MAX_CLUSTERS + 1)-1:0]           csr_data
);

   localparam int CI_BITS  = $clog2(MAX_CLUSTERS);
   localparam int FI_BITS  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CNT_BITS = $clog2(MAX_CLUSTERS + 1);
   localparam int ACC_BITS = ncc_pkg::ACC_BITS;

   // cluster_count register and its effective value
   logic [CNT_BITS-1:0]             count_ff;
   logic [CNT_BITS-1:0]             count_eff;

   // post-reset memory clear
   logic                            clr_busy_ff;
   logic [FI_BITS-1:0]              clr_addr_ff;

   logic                            loaded_ff;
   logic                            en;
   logic                            accept;
   logic                            in_range;

   // chain links
   ncc_pkg::item_ctrl_type          item_ctrl_in   [MAX_CLUSTERS];
   logic [CI_BITS-1:0]              item_ci_in     [MAX_CLUSTERS];
   logic [FI_BITS-1:0]              item_fi_in     [MAX_CLUSTERS];
   logic signed [VALUE_BITS-1:0]    item_value_in  [MAX_CLUSTERS];
   ncc_pkg::item_ctrl_type          item_ctrl_out  [MAX_CLUSTERS];
   logic [CI_BITS-1:0]              item_ci_out    [MAX_CLUSTERS];
   logic [FI_BITS-1:0]              item_fi_out    [MAX_CLUSTERS];
   logic signed [VALUE_BITS-1:0]    item_value_out [MAX_CLUSTERS];
   ncc_pkg::best_ctrl_type          best_ctrl_in   [MAX_CLUSTERS];
   logic [CI_BITS-1:0]              best_cl_in     [MAX_CLUSTERS];
   logic signed [ACC_BITS-1:0]      best_sc_in     [MAX_CLUSTERS];
   ncc_pkg::best_ctrl_type          best_ctrl_out  [MAX_CLUSTERS];
   logic [CI_BITS-1:0]              best_cl_out    [MAX_CLUSTERS];
   logic signed [ACC_BITS-1:0]      best_sc_out    [MAX_CLUSTERS];

   ncc_pkg::best_ctrl_type          chain_ctrl;
   logic [CI_BITS-1:0]              chain_cluster;
   logic signed [ACC_BITS-1:0]      chain_score;

   // result as it leaves the chain
   logic [CI_BITS-1:0]              res_cluster;
   logic signed [ACC_BITS-1:0]      res_score;
   logic                            res_status;
   logic                            push;
   logic                            pop;

   logic                            rsp_valid_ff;
   logic [CI_BITS-1:0]              rsp_cluster_ff;
   logic signed [ACC_BITS-1:0]      rsp_score_ff;
   logic                            rsp_status_ff;

   // spare result register, filled while the output one waits
   logic                            skid_valid_ff;
   logic [CI_BITS-1:0]              skid_cluster_ff;
   logic signed [ACC_BITS-1:0]      skid_score_ff;
   logic                            skid_status_ff;

   // ---- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_BITS'(MAX_CLUSTERS);
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   // zero acts as one, anything above the cell count as the cell count
   always_comb begin
      if (count_ff == '0) begin
         count_eff = CNT_BITS'(1);
      end else if (count_ff > CNT_BITS'(MAX_CLUSTERS)) begin
         count_eff = CNT_BITS'(MAX_CLUSTERS);
      end else begin
         count_eff = count_ff;
      end
   end

   // ---- clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + FI_BITS'(1);
         if (clr_addr_ff == FI_BITS'(MAX_FEATURES - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ---- input side
   // hold the whole chain only when a result would hit a full spare register
   assign en        = !(chain_ctrl.valid && skid_valid_ff);
   assign req_ready = en && !clr_busy_ff;
   assign accept    = req_valid && req_ready;

   // out-of-range loads are dropped; out-of-range features add nothing
   assign in_range = ({1'b0, req_feature_index} < (FI_BITS + 1)'(MAX_FEATURES)) &&
                     ((req_type == ncc_pkg::REQ_FEATURE) ||
                      ({1'b0, req_centroid_index} < (CI_BITS + 1)'(MAX_CLUSTERS)));

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
      end else if (accept && (req_type == ncc_pkg::REQ_LOAD) && in_range) begin
         loaded_ff <= 1'b1;
      end
   end

   // ---- cell chain
   assign item_ctrl_in[0] = '{valid:    accept,
                              feature:  (req_type == ncc_pkg::REQ_FEATURE),
                              last:     req_last,
                              loaded:   loaded_ff,
                              in_range: in_range};

   assign item_ci_in[0]    = req_centroid_index;
   assign item_fi_in[0]    = req_feature_index;
   assign item_value_in[0] = req_value;
   assign best_ctrl_in[0]  = '0;
   assign best_cl_in[0]    = '0;
   assign best_sc_in[0]    = '0;

   for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
      if (c > 0) begin : g_link
         assign item_ctrl_in[c]  = item_ctrl_out[c-1];
         assign item_ci_in[c]    = item_ci_out[c-1];
         assign item_fi_in[c]    = item_fi_out[c-1];
         assign item_value_in[c] = item_value_out[c-1];
         assign best_ctrl_in[c]  = best_ctrl_out[c-1];
         assign best_cl_in[c]    = best_cl_out[c-1];
         assign best_sc_in[c]    = best_sc_out[c-1];
      end

      ncc_cell #(
         .CELL_INDEX   (c),
         .MAX_CLUSTERS (MAX_CLUSTERS),
         .MAX_FEATURES (MAX_FEATURES),
         .VALUE_BITS   (VALUE_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .en             (en),
         .clr_active     (clr_busy_ff),
         .clr_addr       (clr_addr_ff),
         .count_eff      (count_eff),
         .item_ctrl_i    (item_ctrl_in[c]),
         .item_ci_i      (item_ci_in[c]),
         .item_fi_i      (item_fi_in[c]),
         .item_value_i   (item_value_in[c]),
         .item_ctrl_o    (item_ctrl_out[c]),
         .item_ci_o      (item_ci_out[c]),
         .item_fi_o      (item_fi_out[c]),
         .item_value_o   (item_value_out[c]),
         .best_ctrl_i    (best_ctrl_in[c]),
         .best_cluster_i (best_cl_in[c]),
         .best_score_i   (best_sc_in[c]),
         .best_ctrl_o    (best_ctrl_out[c]),
         .best_cluster_o (best_cl_out[c]),
         .best_score_o   (best_sc_out[c])
      );
   end

   assign chain_ctrl    = best_ctrl_out[MAX_CLUSTERS-1];
   assign chain_cluster = best_cl_out[MAX_CLUSTERS-1];
   assign chain_score   = best_sc_out[MAX_CLUSTERS-1];

   // nothing loaded gives cluster 0, score 0, empty status
   assign res_cluster = chain_ctrl.loaded ? chain_cluster : '0;
   assign res_score   = chain_ctrl.loaded ? chain_score : '0;
   assign res_status  = chain_ctrl.loaded ? ncc_pkg::STATUS_OK : ncc_pkg::STATUS_EMPTY;

   assign push = en && chain_ctrl.valid;
   assign pop  = rsp_valid_ff && rsp_ready;

   // ---- result register plus spare; the spare drains first to keep order
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_valid_ff   <= 1'b1;
            rsp_cluster_ff <= skid_cluster_ff;
            rsp_score_ff   <= skid_score_ff;
            rsp_status_ff  <= skid_status_ff;
            skid_valid_ff  <= 1'b0;
         end else if (push) begin
            rsp_valid_ff   <= 1'b1;
            rsp_cluster_ff <= res_cluster;
            rsp_score_ff   <= res_score;
            rsp_status_ff  <= res_status;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (push) begin
         skid_valid_ff   <= 1'b1;
         skid_cluster_ff <= res_cluster;
         skid_score_ff   <= res_score;
         skid_status_ff  <= res_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cluster    = rsp_cluster_ff;
   assign rsp_best_score = rsp_score_ff;
   assign rsp_status     = rsp_status_ff;

   `NCC_ASSERT_IMPL(a_clear_blocks_req, clock, reset, clr_busy_ff, !req_ready)
   `NCC_ASSERT_NEXT(a_stall_holds_end, clock, reset, !en, $stable(chain_ctrl) && $stable(chain_score))
   `NCC_ASSERT_IMPL(a_status_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == ncc_pkg::STATUS_EMPTY), (rsp_score_ff == '0) && (rsp_cluster_ff == '0))
   `NCC_ASSERT_IMPL(a_spare_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff)

endmodule

// ----- tb/tb_nearest_centroid_classifier_core.sv -----
// Self-checking testbench for the nearest-centroid classifier core.
`timescale 1ns / 1ps

module tb_nearest_centroid_classifier_core;

   localparam int N_CLUSTERS     = 16;
   localparam int FEATURE_SLOTS  = 64;
   localparam int VALUE_W        = 16;
   localparam int RESULT_LATENCY = N_CLUSTERS + 4;
   localparam int SETTLE_CYCLES  = RESULT_LATENCY + 8;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int N_PHASES       = 8;

   // item kinds and result status codes
   localparam bit ITEM_LOAD    = ncc_pkg::REQ_LOAD;
   localparam bit ITEM_FEATURE = ncc_pkg::REQ_FEATURE;
   localparam bit STATUS_OK    = ncc_pkg::STATUS_OK;
   localparam bit STATUS_EMPTY = ncc_pkg::STATUS_EMPTY;

   // saturation bounds of the accumulators, scores and squared norms
   localparam longint ACC_MAX  = (longint'(1) <<< (ncc_pkg::ACC_BITS - 1)) - 1;
   localparam longint ACC_MIN  = -ACC_MAX - 1;
   localparam longint NORM_MAX = (longint'(1) <<< ncc_pkg::NORM_BITS) - 1;

   typedef struct {
      logic [3:0]                          cluster;
      logic signed [ncc_pkg::ACC_BITS-1:0] score;
      logic                                status;
   } nearest_result_type;

   // Scoreboard: mirrors the centroid store, norms and dot accumulators,
   // turns the last feature of every accepted sample into its expected result and checks results in order.
   class centroid_scoreboard;
      logic signed [VALUE_W-1:0] element [N_CLUSTERS][FEATURE_SLOTS];
      longint                    norm [N_CLUSTERS];
      longint                    dot [N_CLUSTERS];
      bit                        loaded;
      logic [4:0]                cluster_count;
      nearest_result_type        expected_results[$];
      int                        failures;
      int                        reported;

      function new();
         foreach (element[c, f]) element[c][f] = '0;
         foreach (norm[c]) begin
            norm[c] = 0;
            dot[c]  = 0;
         end
         loaded        = 1'b0;
         cluster_count = 5'd16;
         failures      = 0;
         reported      = 0;
      endfunction

      function longint clamp(longint x, longint lo, longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      function longint sat_add(longint a, longint b);
         return clamp(a + b, ACC_MIN, ACC_MAX);
      endfunction

      function void set_cluster_count(logic [4:0] value);
         cluster_count = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void take_item(bit kind, logic [3:0] ci, logic [5:0] fi,
                              logic signed [VALUE_W-1:0] v, bit last);
         longint             old_sq;
         longint             n;
         longint             p;
         longint             s;
         longint             best_score;
         int                 k;
         int                 best;
         nearest_result_type r;
         if (kind == ITEM_LOAD) begin
            // norm tracks the store: add the new square, drop the replaced one
            old_sq = longint'(element[ci][fi]) * longint'(element[ci][fi]);
            n = clamp(norm[ci] + longint'(v) * longint'(v), 0, NORM_MAX);
            norm[ci] = clamp(n - old_sq, 0, NORM_MAX);
            element[ci][fi] = v;
            loaded = 1'b1;
            return;
         end
         for (int c = 0; c < N_CLUSTERS; c++) begin
            p = longint'(v) * longint'(element[c][fi]);
            dot[c] = sat_add(dot[c], -p);
            dot[c] = sat_add(dot[c], -p);
         end
         if (!last) return;
         k = cluster_count;
         if (k < 1) k = 1;
         if (k > N_CLUSTERS) k = N_CLUSTERS;
         best = 0;
         best_score = 0;
         if (loaded) begin
            best_score = sat_add(norm[0], dot[0]);
            for (int c = 1; c < k; c++) begin
               s = sat_add(norm[c], dot[c]);
               if (s < best_score) begin
                  best_score = s;
                  best = c;
               end
            end
         end
         r.cluster = best[3:0];
         r.score   = best_score[ncc_pkg::ACC_BITS-1:0];
         r.status  = loaded ? STATUS_OK : STATUS_EMPTY;
         expected_results.push_back(r);
         foreach (dot[c]) dot[c] = 0;
      endfunction

      function void check_result(logic [3:0] cluster,
                                 logic signed [ncc_pkg::ACC_BITS-1:0] score,
                                 logic status);
         nearest_result_type e;
         if (expected_results.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("unexpected result: cluster %0d score %0d status %0d",
                        cluster, score, status);
            end
            return;
         end
         e = expected_results.pop_front();
         if (cluster !== e.cluster || score !== e.score || status !== e.status) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("mismatch: expected cluster %0d score %0d status %0d, got %0d %0d %0d",
                        e.cluster, e.score, e.status, cluster, score, status);
            end
         end
      endfunction

      function void close_out();
         if (expected_results.size() != 0) begin
            failures += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic                               req_type;
   logic [3:0]                         req_centroid_index;
   logic [5:0]                         req_feature_index;
   logic signed [VALUE_W-1:0]          req_value;
   logic                               req_last;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [3:0]                         rsp_cluster;
   logic signed [ncc_pkg::ACC_BITS-1:0] rsp_best_score;
   logic                               rsp_status;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [4:0]                         csr_data;

   centroid_scoreboard sb;

   // idling knobs in percent, per item for the sender and per cycle for the receiver; changed only between phases
   int send_idle_pct;
   int rsp_stall_pct;
   // long receiver hold-off requested by the stimulus, served by the receiver
   int hold_request;
   int items_sent;

   nearest_centroid_classifier_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_centroid_index (req_centroid_index),
      .req_feature_index  (req_feature_index),
      .req_value          (req_value),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cluster        (rsp_cluster),
      .rsp_best_score     (rsp_best_score),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run (including the memory
   // clearing pass after reset and the long receiver hold-off).
   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

   // Drive one item from the falling edge and hold it until taken. Valid is
   // left high so back-to-back items need no reassertion.
   task automatic send_item(input bit kind, input logic [3:0] ci, input logic [5:0] fi,
                            input logic signed [VALUE_W-1:0] v, input bit last);
      @(negedge clock);
      req_valid          = 1'b1;
      req_type           = kind;
      req_centroid_index = ci;
      req_feature_index  = fi;
      req_value          = v;
      req_last           = last;
      do @(posedge clock); while (!req_ready);
      sb.take_item(kind, ci, fi, v, last);
      items_sent++;
   endtask

   // Random sender gap with valid dropped, taken with a chance of send_idle_pct percent.
   task automatic sender_gap();
      if ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   task automatic write_cluster_count(input logic [4:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.set_cluster_count(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Wait for every expected result, then let loads still in the chain
   // (they give no result) work their way out.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Feature and centroid values: extremes, small values that make ties likely,
   // and full-range noise.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      if (r < 40) return VALUE_W'($signed($urandom_range(0, 16)) - 8);
      return VALUE_W'($urandom);
   endfunction

   // A well-formed sample: consecutive feature positions, last on the final one.
   task automatic send_sample(input int len);
      logic [5:0] fi;
      fi = 6'($urandom);
      for (int i = 0; i < len; i++) begin
         send_item(ITEM_FEATURE, 4'($urandom), fi, pick_value(), i == len - 1);
         sender_gap();
         fi++;
      end
   endtask

   task automatic run_random(input int n_items);
      int target;
      int r;
      int len;
      target = items_sent + n_items;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            // burst of centroid loads; the last mark on a load is noise
            repeat ($urandom_range(1, 6)) begin
               send_item(ITEM_LOAD, 4'($urandom), 6'($urandom), pick_value(), 1'($urandom));
               sender_gap();
            end
         end else if (r < 90) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                              : $urandom_range(1, 12);
            send_sample(len);
         end else begin
            send_item(1'($urandom), 4'($urandom), 6'($urandom), VALUE_W'($urandom),
                      1'($urandom));
            sender_gap();
         end
      end
   endtask

   // Receiver: random stalls per cycle, plus a long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_cluster, rsp_best_score, rsp_status);
      end
   end

   initial begin
      logic [4:0] phase_counts [N_PHASES];
      sb = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_type           = ITEM_LOAD;
      req_centroid_index = '0;
      req_feature_index  = '0;
      req_value          = '0;
      req_last           = 1'b0;
      csr_valid          = 1'b0;
      csr_data           = '0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      hold_request       = 0;
      items_sent         = 0;
      // register settings per phase: reset value, both ends, 0 and above range
      phase_counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd9, 5'd16};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_cluster_count(5'd16);

      // --- directed part ---
      // sample before anything is loaded: empty status, zero score
      send_item(ITEM_FEATURE, 4'd0, 6'd5, 16'sh8000, 1'b1);
      // last mark on a load is ignored
      send_item(ITEM_LOAD, 4'd3, 6'd0, 16'sh7FFF, 1'b1);
      // two centroids with equal elements tie, lower index wins
      send_item(ITEM_LOAD, 4'd0, 6'd0, 16'sh8000, 1'b0);
      send_item(ITEM_LOAD, 4'd1, 6'd0, 16'sh8000, 1'b0);
      send_item(ITEM_LOAD, 4'd15, 6'd63, 16'sh7FFF, 1'b0);
      // overwrite an element: its old square leaves the norm
      send_item(ITEM_LOAD, 4'd2, 6'd63, 16'sh8000, 1'b0);
      send_item(ITEM_LOAD, 4'd2, 6'd63, 16'sd100, 1'b0);
      send_item(ITEM_FEATURE, 4'd9, 6'd0, 16'sh8000, 1'b0);
      send_item(ITEM_FEATURE, 4'd0, 6'd63, 16'sh7FFF, 1'b1);
      send_item(ITEM_FEATURE, 4'd0, 6'd0, 16'sh7FFF, 1'b1);
      // load in the middle of a sample: earlier features keep the old element
      send_item(ITEM_FEATURE, 4'd0, 6'd0, 16'sd1000, 1'b0);
      send_item(ITEM_LOAD, 4'd0, 6'd0, 16'sd5, 1'b0);
      send_item(ITEM_FEATURE, 4'd0, 6'd0, -16'sd5, 1'b0);
      send_item(ITEM_FEATURE, 4'd0, 6'd1, -16'sd5, 1'b1);
      // zero dot products: scores are the norms, many zero-norm ties
      send_item(ITEM_FEATURE, 4'd0, 6'd40, 16'sd0, 1'b1);
      send_item(ITEM_LOAD, 4'd15, 6'd0, 16'shFFFF, 1'b0);
      send_item(ITEM_FEATURE, 4'd15, 6'd0, 16'sh8000, 1'b0);
      send_item(ITEM_FEATURE, 4'd15, 6'd63, 16'sh8000, 1'b1);
      wait_idle();

      // --- random phases, idling mode rotates, register changes while idle ---
      for (int ph = 0; ph < N_PHASES; ph++) begin
         write_cluster_count(phase_counts[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
            default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         run_random(ITEMS_PER_PHASE);
         wait_idle();
      end

      // --- back-pressure: receiver holds off, sender keeps offering short samples ---
      write_cluster_count(5'd16);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 400;
      repeat (60) send_sample(1);
      // sender pauses until every result is out, then resumes
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) send_sample($urandom_range(1, 4));
      wait_idle();

      sb.close_out();
      if (sb.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ncc_pkg.sv
sv/ncc_cell.sv
sv/nearest_centroid_classifier_core.sv
tb/tb_nearest_centroid_classifier_core.sv
